// ===== rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared widths, request and response codes, and the transfer payload types.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int INDEX_BITS   = 10;
   localparam int VERSION_BITS = 6;
   localparam int HANDLE_BITS  = INDEX_BITS + VERSION_BITS;
   localparam int KIND_BITS    = 3;
   localparam int STATUS_BITS  = 2;

   localparam logic [HANDLE_BITS-1:0] NULL_HANDLE = {HANDLE_BITS{1'b1}};
   localparam logic [INDEX_BITS-1:0]  NULL_INDEX  = {INDEX_BITS{1'b1}};
   localparam logic [INDEX_BITS:0]    MAX_SLOTS   = {1'b0, {INDEX_BITS{1'b1}}};

   localparam logic [KIND_BITS-1:0] KIND_CREATE     = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_DESTROY    = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_CHECK      = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_SET_PARENT = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_GET_PARENT = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [HANDLE_BITS-1:0] handle;
      logic [HANDLE_BITS-1:0] parent_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] result_handle;
      logic                   is_valid;
      logic [STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]  live_count;
   } rsp_type;

   typedef struct packed {
      logic                   slot_we;
      logic                   parent_we;
      logic [INDEX_BITS-1:0]  addr;
      logic [HANDLE_BITS-1:0] slot_data;
      logic [HANDLE_BITS-1:0] parent_data;
   } tbl_wr_type;

   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] addr;
   } tbl_rd_type;

endpackage

// ===== rtl/gha_tables.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator slot and parent tables
// Two synchronous memories with separate read and write ports that share one
// read and one write address, with read data registered the cycle after issue.
// ----------------------------------------------------------------------------
module gha_tables
   import gha_pkg::*;
(
   input  logic                   clock,
   input  tbl_rd_type             rd,
   input  tbl_wr_type             wr,
   output logic [HANDLE_BITS-1:0] rd_slot,
   output logic [HANDLE_BITS-1:0] rd_parent
);

   localparam int DEPTH = 1 << INDEX_BITS;

   logic [HANDLE_BITS-1:0] slot_ram_ff   [DEPTH];
   logic [HANDLE_BITS-1:0] parent_ram_ff [DEPTH];
   logic [HANDLE_BITS-1:0] rd_slot_ff;
   logic [HANDLE_BITS-1:0] rd_parent_ff;

   always_ff @(posedge clock) begin
      if (wr.slot_we) begin
         slot_ram_ff[wr.addr] <= wr.slot_data;
      end
      if (rd.en) begin
         rd_slot_ff <= slot_ram_ff[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.parent_we) begin
         parent_ram_ff[wr.addr] <= wr.parent_data;
      end
      if (rd.en) begin
         rd_parent_ff <= parent_ram_ff[rd.addr];
      end
   end

   assign rd_slot   = rd_slot_ff;
   assign rd_parent = rd_parent_ff;

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out handles of a slot index and a version, reusing freed slots from
// a free list threaded through the slot table.
// ----------------------------------------------------------------------------
// A request transfer on req_ carries a kind, a target handle and a parent
// handle. Each request produces exactly one response transfer on rsp_ with
// the resulting handle, the liveness of the target, a status code and the
// number of live handles after the request.
// A request is taken in a cycle that also issues the table read; the
// next cycle evaluates it, writes the tables back and loads the response
// register, which offers the response. No new request is taken while one
// is being evaluated, since the registered read of the slot table is
// followed by its write-back and the free-list head update that the next
// request depends on.
// The response register holds its contents while rsp_stall is high; a new
// request is only taken when that register is empty or is being drained in
// the same cycle, so a stalled receiver stalls the requester in turn.
// Reset empties the free list, clears the slot and live counts and drops any
// pending response. The tables need no clearing, as only written slots are
// ever examined.
// ----------------------------------------------------------------------------
module generational_handle_allocator
   import gha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                    state_ff, state_in;
   req_type                 req_ff;
   logic [INDEX_BITS-1:0]   free_head_ff, free_head_in;
   logic [INDEX_BITS:0]     slots_used_ff, slots_used_in;
   logic [INDEX_BITS-1:0]   live_total_ff, live_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   tbl_rd_type              tbl_rd;
   tbl_wr_type              tbl_wr;
   logic [HANDLE_BITS-1:0]  rd_slot;
   logic [HANDLE_BITS-1:0]  rd_parent;
   logic [INDEX_BITS-1:0]   tgt_index;
   logic                    tgt_live;
   logic [VERSION_BITS-1:0] next_version;

   gha_tables u_tables (
      .clock     (clock),
      .rd        (tbl_rd),
      .wr        (tbl_wr),
      .rd_slot   (rd_slot),
      .rd_parent (rd_parent)
   );

   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   assign tbl_rd.en   = req_accept;
   assign tbl_rd.addr = (req_data.kind == KIND_CREATE) ? free_head_ff
                                                       : req_data.handle[INDEX_BITS-1:0];

   assign tgt_index    = req_ff.handle[INDEX_BITS-1:0];
   assign tgt_live     = (req_ff.handle != NULL_HANDLE)
                         && ({1'b0, tgt_index} < slots_used_ff)
                         && (rd_slot == req_ff.handle);
   assign next_version = req_ff.handle[HANDLE_BITS-1:INDEX_BITS] + 1'b1;

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      slots_used_in = slots_used_ff;
      live_total_in = live_total_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      tbl_wr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in                  = ST_IDLE;
            rsp_valid_in              = 1'b1;
            rsp_data_in.result_handle = NULL_HANDLE;
            rsp_data_in.is_valid      = 1'b0;
            rsp_data_in.status        = STATUS_OK;
            unique case (req_ff.kind)
               KIND_CREATE: begin
                  if (free_head_ff != NULL_INDEX) begin
                     tbl_wr.slot_we = 1'b1;
                     tbl_wr.addr    = free_head_ff;
                     tbl_wr.slot_data = {rd_slot[HANDLE_BITS-1:INDEX_BITS], free_head_ff};
                     free_head_in   = rd_slot[INDEX_BITS-1:0];
                  end else if (slots_used_ff < MAX_SLOTS) begin
                     tbl_wr.slot_we   = 1'b1;
                     tbl_wr.addr      = slots_used_ff[INDEX_BITS-1:0];
                     tbl_wr.slot_data = {{VERSION_BITS{1'b0}},
                                         slots_used_ff[INDEX_BITS-1:0]};
                     slots_used_in    = slots_used_ff + 1'b1;
                  end
                  if (tbl_wr.slot_we) begin
                     tbl_wr.parent_we          = 1'b1;
                     tbl_wr.parent_data        = NULL_HANDLE;
                     live_total_in             = live_total_ff + 1'b1;
                     rsp_data_in.result_handle = tbl_wr.slot_data;
                     rsp_data_in.is_valid      = 1'b1;
                  end else begin
                     rsp_data_in.status = STATUS_FULL;
                  end
               end
               KIND_DESTROY: begin
                  rsp_data_in.is_valid = tgt_live;
                  if (tgt_live) begin
                     tbl_wr.slot_we   = 1'b1;
                     tbl_wr.addr      = tgt_index;
                     tbl_wr.slot_data = {next_version, free_head_ff};
                     free_head_in     = tgt_index;
                     live_total_in    = live_total_ff - 1'b1;
                  end else begin
                     rsp_data_in.status = STATUS_INVALID;
                  end
               end
               KIND_CHECK: begin
                  rsp_data_in.is_valid = tgt_live;
               end
               KIND_SET_PARENT: begin
                  rsp_data_in.is_valid = tgt_live;
                  if (tgt_live) begin
                     tbl_wr.parent_we   = 1'b1;
                     tbl_wr.addr        = tgt_index;
                     tbl_wr.parent_data = req_ff.parent_handle;
                  end else begin
                     rsp_data_in.status = STATUS_INVALID;
                  end
               end
               KIND_GET_PARENT: begin
                  rsp_data_in.is_valid = tgt_live;
                  if (tgt_live) begin
                     rsp_data_in.result_handle = rd_parent;
                  end else begin
                     rsp_data_in.status = STATUS_INVALID;
                  end
               end
               default: begin
                  rsp_data_in.is_valid = 1'b0;
               end
            endcase
            rsp_data_in.live_count = live_total_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= NULL_INDEX;
         slots_used_ff <= '0;
         live_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         slots_used_ff <= slots_used_in;
         live_total_ff <= live_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A live slot has always been handed out, so the live count cannot pass the slot count.
   a_live_within_used: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, live_total_ff} <= slots_used_ff))
      else $error("live count exceeds slots in use");

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      (slots_used_ff <= MAX_SLOTS))
      else $error("slot count beyond the last usable index");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      ((free_head_ff == NULL_INDEX) || ({1'b0, free_head_ff} < slots_used_ff)))
      else $error("free-list head names a slot never handed out");

   // The response register must be free when a request is evaluated.
   a_exec_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("response register occupied during evaluation");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ##1 rsp_valid_ff)
      else $error("request transfer not answered after two cycles");

endmodule
